// ===== src/utf8_stream_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_macros.svh
// Assertion macros used by the UTF-8 stream decoder (utf8_stream_decoder.sv).
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define UTF8SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a condition that must hold on every clock edge outside reset.
`define UTF8SD_ASSERT_ALWAYS(label, cond, msg) \
  `UTF8SD_ASSERT(label, 1'b1 |-> (cond), msg)

`endif

// ===== src/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PART_W = 18;
  localparam int unsigned CNT_W  = 2;

  // Result kind carried on tuser.
  typedef enum logic [1:0] {
    ST_CHAR    = 2'd0,
    ST_END     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Decoder state carried between words.
  typedef struct packed {
    logic [CNT_W-1:0]  pending;
    logic [PART_W-1:0] partial;
    logic              discard;
  } dec_state_t;

  // One decode result.
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] code_point;
    status_t         status;
  } dec_result_t;

endpackage

`default_nettype wire

// ===== src/utf8sd_step.sv =====
// ----------------------------------------------------------------------------
// utf8sd_step
// Per-byte decode logic: next decoder state and the optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_step (
  input  wire logic [utf8sd_pkg::BYTE_W-1:0] data_byte,
  input  wire utf8sd_pkg::dec_state_t        cur,
  output utf8sd_pkg::dec_state_t             nxt,
  output utf8sd_pkg::dec_result_t            res
);

  logic                                      is_cont;
  logic [utf8sd_pkg::PART_W+5:0]             shifted;

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign shifted = {cur.partial, data_byte[5:0]};

  always_comb begin
    nxt            = cur;
    res.valid      = 1'b0;
    res.code_point = '0;
    res.status     = utf8sd_pkg::ST_CHAR;

    if (data_byte == '0) begin
      // Terminator: drops any open character and clears all state.
      nxt        = '0;
      res.valid  = 1'b1;
      res.status = utf8sd_pkg::ST_END;
    end else if (cur.discard) begin
      nxt = cur;
    end else if (cur.pending != '0) begin
      if (!is_cont) begin
        nxt         = '0;
        nxt.discard = 1'b1;
        res.valid   = 1'b1;
        res.status  = utf8sd_pkg::ST_INVALID;
      end else begin
        nxt.pending = cur.pending - 2'd1;
        if (cur.pending == 2'd1) begin
          nxt.partial    = '0;
          res.valid      = 1'b1;
          res.code_point = shifted[utf8sd_pkg::CP_W-1:0];
        end else begin
          nxt.partial = shifted[utf8sd_pkg::PART_W-1:0];
        end
      end
    end else begin
      unique case (data_byte) inside
        8'b10??????: begin
          // Stray continuation word where a character should start.
          nxt = cur;
        end
        8'b0???????: begin
          res.valid      = 1'b1;
          res.code_point = {13'd0, data_byte};
        end
        8'b110?????: begin
          nxt.pending = 2'd1;
          nxt.partial = {13'd0, data_byte[4:0]};
        end
        8'b1110????: begin
          nxt.pending = 2'd2;
          nxt.partial = {14'd0, data_byte[3:0]};
        end
        8'b11110???: begin
          nxt.pending = 2'd3;
          nxt.partial = {15'd0, data_byte[2:0]};
        end
        default: begin
          nxt         = '0;
          nxt.discard = 1'b1;
          res.valid   = 1'b1;
          res.status  = utf8sd_pkg::ST_INVALID;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a zero-terminated UTF-8 byte stream into code points.
// ----------------------------------------------------------------------------
// Usage: bytes arrive one per word on the in_ channel, and decoded results
// leave on the out_ channel. Both channels move a word on a clock edge where
// tvalid and tready are high together. Each input word produces zero or one
// result: one for a complete character, for the zero terminator (end) and for
// a broken sequence (invalid); lead and continuation words inside a character,
// stray continuation words and all other words in discard mode produce none.
// An accepted word is held in the input register, decoded, and its result
// registered in the result register, where it is visible on the out_ ports.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single decode step between the input and result registers.
// A synchronous active-low reset empties both registers and clears the
// decoder state. When the receiver stalls, the result register holds its
// word, the input register holds one more, and in_tready then drops until
// out_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  // Input register stage.
  logic                               in_valid_r;
  logic [utf8sd_pkg::BYTE_W-1:0]      in_byte_r;

  // Decoder state, updated when the held word is decoded.
  utf8sd_pkg::dec_state_t             st_r;
  utf8sd_pkg::dec_state_t             st_nxt;
  utf8sd_pkg::dec_result_t            res;

  // Result register stage.
  logic                               out_valid_r;
  logic [utf8sd_pkg::CP_W-1:0]        out_cp_r;
  utf8sd_pkg::status_t                out_status_r;

  logic                               out_free;
  logic                               advance;

  // The held word is decoded when the result register can take a new word.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;

  utf8sd_step u_step (
    .data_byte (in_byte_r),
    .cur       (st_r),
    .nxt       (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid && out_free) begin
      out_cp_r     <= res.code_point;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_cp_r};
  assign out_tuser  = out_status_r;

  // A decoded terminator leaves the decoder fully cleared.
  `UTF8SD_ASSERT(a_term_clears, advance && (in_byte_r == '0) |=> (st_r == '0),
                 "terminator did not clear state")
  // Discard mode never keeps an open character.
  `UTF8SD_ASSERT_ALWAYS(a_discard_idle, !st_r.discard || (st_r.pending == '0),
                        "open character in discard mode")
  // With no character open, no partial bits are kept.
  `UTF8SD_ASSERT_ALWAYS(a_partial_clear, (st_r.pending != '0) || (st_r.partial == '0),
                        "stale partial value")
  // End and invalid results carry a zero code point.
  `UTF8SD_ASSERT_ALWAYS(a_zero_cp,
                        !out_valid_r || (out_status_r == utf8sd_pkg::ST_CHAR) ||
                        (out_cp_r == '0),
                        "nonzero code point in end or invalid result")

endmodule

`default_nettype wire
